>>> src/wua_pkg.sv
// Shared types and constants for the 256-bit unsigned ALU.
package wua_pkg;

    localparam int NUM_W     = 256;
    localparam int WORD_W    = 64;
    localparam int LIMB_W    = 32;
    localparam int NUM_LIMBS = NUM_W / LIMB_W;
    localparam int ROW_W     = NUM_W + LIMB_W;
    localparam int PROD_W    = 2 * NUM_W;
    localparam int CNT_W     = 9;
    localparam int OP_W      = 5;

    typedef logic [NUM_W-1:0] num_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_MUL    = 5'd2,
        OP_DIV    = 5'd3,
        OP_MOD    = 5'd4,
        OP_LT     = 5'd5,
        OP_GT     = 5'd6,
        OP_LE     = 5'd7,
        OP_GE     = 5'd8,
        OP_EQ     = 5'd9,
        OP_NE     = 5'd10,
        OP_PASS   = 5'd11,
        OP_NEGATE = 5'd12,
        OP_AND    = 5'd13,
        OP_OR     = 5'd14,
        OP_XOR    = 5'd15,
        OP_NOT    = 5'd16,
        OP_SHL    = 5'd17,
        OP_SHR    = 5'd18
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef struct packed {
        num_t    value;
        logic    flag;
        status_t status;
    } res_t;

    typedef struct packed {
        op_t  op;
        num_t a;
        num_t b;
        res_t res;
    } item_t;

    typedef struct packed {
        op_t  op;
        res_t res;
    } div_item_t;

endpackage

>>> src/wua_simple.sv
// First stage: add, subtract, compare, logic and shifts; flags for the other ops.
module wua_simple (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  wua_pkg::op_t               op,
    input  wua_pkg::num_t              a,
    input  wua_pkg::num_t              b,
    input  logic [wua_pkg::CNT_W-1:0]  cnt,
    output logic                       out_valid,
    output wua_pkg::item_t             out_item
);

    logic [wua_pkg::NUM_W:0] sum;
    logic [wua_pkg::NUM_W:0] diff;
    logic                    lt;
    logic                    eq;
    wua_pkg::num_t           shl;
    wua_pkg::num_t           shr;
    wua_pkg::res_t           res_next;
    logic                    valid_reg;
    wua_pkg::item_t          item_reg;

    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        lt   = diff[wua_pkg::NUM_W];
        eq   = (a == b);
        shl  = cnt[wua_pkg::CNT_W-1] ? '0 : (a << cnt[wua_pkg::CNT_W-2:0]);
        shr  = cnt[wua_pkg::CNT_W-1] ? '0 : (a >> cnt[wua_pkg::CNT_W-2:0]);

        res_next.value  = '0;
        res_next.flag   = 1'b0;
        res_next.status = wua_pkg::ST_OK;

        case (op)
            wua_pkg::OP_ADD:
            begin
                if (sum[wua_pkg::NUM_W])
                    res_next.status = wua_pkg::ST_RANGE;
                else
                    res_next.value = sum[wua_pkg::NUM_W-1:0];
            end
            wua_pkg::OP_SUB:
            begin
                if (diff[wua_pkg::NUM_W])
                    res_next.status = wua_pkg::ST_RANGE;
                else
                    res_next.value = diff[wua_pkg::NUM_W-1:0];
            end
            wua_pkg::OP_DIV, wua_pkg::OP_MOD:
            begin
                if (b == '0)
                    res_next.status = wua_pkg::ST_DIVZERO;
            end
            wua_pkg::OP_LT:     res_next.flag = lt;
            wua_pkg::OP_GT:     res_next.flag = !lt && !eq;
            wua_pkg::OP_LE:     res_next.flag = lt || eq;
            wua_pkg::OP_GE:     res_next.flag = !lt;
            wua_pkg::OP_EQ:     res_next.flag = eq;
            wua_pkg::OP_NE:     res_next.flag = !eq;
            wua_pkg::OP_PASS:   res_next.value = a;
            wua_pkg::OP_NEGATE:
            begin
                if (a != '0)
                    res_next.status = wua_pkg::ST_RANGE;
            end
            wua_pkg::OP_AND:    res_next.value = a & b;
            wua_pkg::OP_OR:     res_next.value = a | b;
            wua_pkg::OP_XOR:    res_next.value = a ^ b;
            wua_pkg::OP_NOT:    res_next.value = ~a;
            wua_pkg::OP_SHL:    res_next.value = shl;
            wua_pkg::OP_SHR:    res_next.value = shr;
            default:            res_next.value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg.op  <= op;
            item_reg.a   <= a;
            item_reg.b   <= b;
            item_reg.res <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> src/wua_mul.sv
// Multiplier pipeline: one 32-bit limb row of B per three stages, then merge.
module wua_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  wua_pkg::item_t in_item,
    output logic           out_valid,
    output wua_pkg::item_t out_item
);

    localparam int ROWS = wua_pkg::NUM_LIMBS;
    localparam int HALF = wua_pkg::NUM_LIMBS / 2;
    localparam int PW   = 2 * wua_pkg::LIMB_W;

    logic [ROWS-1:0]           p_valid_reg;
    logic [ROWS-1:0]           r_valid_reg;
    logic [ROWS-1:0]           c_valid_reg;
    wua_pkg::item_t            p_item_reg [ROWS];
    wua_pkg::item_t            r_item_reg [ROWS];
    wua_pkg::item_t            c_item_reg [ROWS];
    logic [wua_pkg::PROD_W-1:0] p_acc_reg [ROWS];
    logic [wua_pkg::PROD_W-1:0] r_acc_reg [ROWS];
    logic [wua_pkg::PROD_W-1:0] c_acc_reg [ROWS];
    logic [PW-1:0]             p_prod_reg [ROWS][wua_pkg::NUM_LIMBS];
    logic [wua_pkg::ROW_W-1:0] r_row_reg [ROWS];

    logic                      ovf;
    wua_pkg::item_t            out_item_next;
    logic                      out_valid_reg;
    wua_pkg::item_t            out_item_reg;

    genvar i, j, k;
    generate
        for (i = 0; i < ROWS; i++)
        begin : g_row
            logic                       src_valid;
            wua_pkg::item_t             src_item;
            logic [wua_pkg::PROD_W-1:0] src_acc;
            wua_pkg::num_t              even_w;
            wua_pkg::num_t              odd_w;
            logic [wua_pkg::ROW_W-1:0]  row_next;
            logic [wua_pkg::PROD_W-1:0] acc_next;

            if (i == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_item  = in_item;
                assign src_acc   = '0;
            end
            else
            begin : g_chain
                assign src_valid = c_valid_reg[i-1];
                assign src_item  = c_item_reg[i-1];
                assign src_acc   = c_acc_reg[i-1];
            end

            for (k = 0; k < HALF; k++)
            begin : g_split
                assign even_w[k*PW +: PW] = p_prod_reg[i][2*k];
                assign odd_w[k*PW +: PW]  = p_prod_reg[i][2*k+1];
            end

            assign row_next = {{wua_pkg::LIMB_W{1'b0}}, even_w}
                            + {odd_w, {wua_pkg::LIMB_W{1'b0}}};

            always_comb
            begin
                acc_next = r_acc_reg[i];
                acc_next[i*wua_pkg::LIMB_W +: wua_pkg::ROW_W] =
                    r_acc_reg[i][i*wua_pkg::LIMB_W +: wua_pkg::ROW_W] + r_row_reg[i];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    p_valid_reg[i] <= 1'b0;
                    r_valid_reg[i] <= 1'b0;
                    c_valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    p_valid_reg[i] <= src_valid;
                    r_valid_reg[i] <= p_valid_reg[i];
                    c_valid_reg[i] <= r_valid_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_item_reg[i] <= src_item;
                    p_acc_reg[i]  <= src_acc;
                    r_item_reg[i] <= p_item_reg[i];
                    r_acc_reg[i]  <= p_acc_reg[i];
                    r_row_reg[i]  <= row_next;
                    c_item_reg[i] <= r_item_reg[i];
                    c_acc_reg[i]  <= acc_next;
                end
            end

            for (j = 0; j < wua_pkg::NUM_LIMBS; j++)
            begin : g_limb
                always_ff @(posedge clk)
                begin
                    if (en)
                        p_prod_reg[i][j] <=
                            {{wua_pkg::LIMB_W{1'b0}}, src_item.a[j*wua_pkg::LIMB_W +: wua_pkg::LIMB_W]}
                          * {{wua_pkg::LIMB_W{1'b0}}, src_item.b[i*wua_pkg::LIMB_W +: wua_pkg::LIMB_W]};
                end
            end
        end
    endgenerate

    always_comb
    begin
        ovf           = |c_acc_reg[ROWS-1][wua_pkg::PROD_W-1:wua_pkg::NUM_W];
        out_item_next = c_item_reg[ROWS-1];
        if (c_item_reg[ROWS-1].op == wua_pkg::OP_MUL)
        begin
            out_item_next.res.flag = 1'b0;
            if (ovf)
            begin
                out_item_next.res.value  = '0;
                out_item_next.res.status = wua_pkg::ST_RANGE;
            end
            else
            begin
                out_item_next.res.value  = c_acc_reg[ROWS-1][wua_pkg::NUM_W-1:0];
                out_item_next.res.status = wua_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid_reg[ROWS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> src/wua_div.sv
// Divider pipeline: one restoring step per stage, then quotient or remainder select.
module wua_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  wua_pkg::item_t in_item,
    output logic           out_valid,
    output wua_pkg::res_t  out_res
);

    localparam int STEPS = wua_pkg::NUM_W;

    logic [STEPS-1:0]      valid_reg;
    wua_pkg::div_item_t    item_reg [STEPS];
    wua_pkg::num_t         rem_reg [STEPS];
    wua_pkg::num_t         qd_reg [STEPS];
    wua_pkg::num_t         dvs_reg [STEPS];

    wua_pkg::res_t         out_res_next;
    logic                  out_valid_reg;
    wua_pkg::res_t         out_res_reg;

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_step
            logic                    src_valid;
            wua_pkg::div_item_t      src_item;
            wua_pkg::num_t           src_rem;
            wua_pkg::num_t           src_qd;
            wua_pkg::num_t           src_dvs;
            logic [wua_pkg::NUM_W:0] shifted;
            logic [wua_pkg::NUM_W:0] trial;
            logic                    take;

            if (s == 0)
            begin : g_first
                assign src_valid    = in_valid;
                assign src_item.op  = in_item.op;
                assign src_item.res = in_item.res;
                assign src_rem      = '0;
                assign src_qd       = in_item.a;
                assign src_dvs      = in_item.b;
            end
            else
            begin : g_chain
                assign src_valid = valid_reg[s-1];
                assign src_item  = item_reg[s-1];
                assign src_rem   = rem_reg[s-1];
                assign src_qd    = qd_reg[s-1];
                assign src_dvs   = dvs_reg[s-1];
            end

            assign shifted = {src_rem, src_qd[wua_pkg::NUM_W-1]};
            assign trial   = shifted - {1'b0, src_dvs};
            assign take    = !trial[wua_pkg::NUM_W];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en)
                    valid_reg[s] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    item_reg[s] <= src_item;
                    dvs_reg[s]  <= src_dvs;
                    rem_reg[s]  <= take ? trial[wua_pkg::NUM_W-1:0]
                                        : shifted[wua_pkg::NUM_W-1:0];
                    qd_reg[s]   <= {src_qd[wua_pkg::NUM_W-2:0], take};
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_res_next = item_reg[STEPS-1].res;
        if (item_reg[STEPS-1].res.status == wua_pkg::ST_OK)
        begin
            if (item_reg[STEPS-1].op == wua_pkg::OP_DIV)
                out_res_next.value = qd_reg[STEPS-1];
            else if (item_reg[STEPS-1].op == wua_pkg::OP_MOD)
                out_res_next.value = rem_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> src/wide_unsigned_alu_256.sv
// Top level of the 256-bit unsigned ALU.
// Input channel: in_valid/in_ready carry one word: opcode, operands A and B
// as four 64-bit words each (word 0 least significant) and shift_count.
// Output channel: out_valid/out_ready carry one result word per input word:
// four 64-bit result words, compare_flag and status (0 ok, 1 out of range,
// 2 division by zero). Result words are zero on any error.
// There are 283 register stages: one for the adder, comparator, logic and
// barrel shifter, 25 for the multiplier (three per 32-bit limb row of B,
// plus a merge stage) and 257 for the divider (one restoring step per
// quotient bit, plus a select stage).
// Every word follows the same path, so results leave in order.
// Throughput is one word per cycle while out_ready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// in_ready is low only then. The pipeline moves or holds as one, so empty
// slots keep their places through a stall.
// Reset clears all valid bits; the pipeline is then empty and ready.
module wide_unsigned_alu_256 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  opcode,
    input  logic [63:0] a_word0,
    input  logic [63:0] a_word1,
    input  logic [63:0] a_word2,
    input  logic [63:0] a_word3,
    input  logic [63:0] b_word0,
    input  logic [63:0] b_word1,
    input  logic [63:0] b_word2,
    input  logic [63:0] b_word3,
    input  logic [8:0]  shift_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] res_word0,
    output logic [63:0] res_word1,
    output logic [63:0] res_word2,
    output logic [63:0] res_word3,
    output logic        compare_flag,
    output logic [1:0]  status
);

    logic           en;
    wua_pkg::num_t  a;
    wua_pkg::num_t  b;
    logic           s_valid;
    wua_pkg::item_t s_item;
    logic           m_valid;
    wua_pkg::item_t m_item;
    wua_pkg::res_t  d_res;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign a        = {a_word3, a_word2, a_word1, a_word0};
    assign b        = {b_word3, b_word2, b_word1, b_word0};

    wua_simple u_simple (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .op        (wua_pkg::op_t'(opcode)),
        .a         (a),
        .b         (b),
        .cnt       (shift_count),
        .out_valid (s_valid),
        .out_item  (s_item)
    );

    wua_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (m_valid),
        .out_item  (m_item)
    );

    wua_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_item   (m_item),
        .out_valid (out_valid),
        .out_res   (d_res)
    );

    assign res_word0    = d_res.value[0*wua_pkg::WORD_W +: wua_pkg::WORD_W];
    assign res_word1    = d_res.value[1*wua_pkg::WORD_W +: wua_pkg::WORD_W];
    assign res_word2    = d_res.value[2*wua_pkg::WORD_W +: wua_pkg::WORD_W];
    assign res_word3    = d_res.value[3*wua_pkg::WORD_W +: wua_pkg::WORD_W];
    assign compare_flag = d_res.flag;
    assign status       = d_res.status;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 256-bit unsigned ALU: random and directed words, scoreboard.
module testbench;

    localparam int LATENCY   = 283;
    localparam int MAX_CYCLE = 2000000;

    typedef struct {
        wua_pkg::num_t    value;
        logic             flag;
        wua_pkg::status_t status;
    } alu_result_t;

    class alu_scoreboard;
        alu_result_t pending[$];
        int          errors;

        function alu_result_t compute(wua_pkg::op_t op, wua_pkg::num_t a, wua_pkg::num_t b,
                                      logic [8:0] cnt);
            alu_result_t r;
            logic [2*wua_pkg::NUM_W-1:0] prod;
            logic [wua_pkg::NUM_W:0]     wide;
            r.value  = '0;
            r.flag   = 1'b0;
            r.status = wua_pkg::ST_OK;
            case (op)
                wua_pkg::OP_ADD:
                begin
                    wide = {1'b0, a} + {1'b0, b};
                    r.value = wide[wua_pkg::NUM_W-1:0];
                    if (wide[wua_pkg::NUM_W]) r.status = wua_pkg::ST_RANGE;
                end
                wua_pkg::OP_SUB:
                begin
                    r.value = a - b;
                    if (a < b) r.status = wua_pkg::ST_RANGE;
                end
                wua_pkg::OP_MUL:
                begin
                    prod = {{wua_pkg::NUM_W{1'b0}}, a} * {{wua_pkg::NUM_W{1'b0}}, b};
                    r.value = prod[wua_pkg::NUM_W-1:0];
                    if (prod[2*wua_pkg::NUM_W-1:wua_pkg::NUM_W] != '0)
                        r.status = wua_pkg::ST_RANGE;
                end
                wua_pkg::OP_DIV:
                    if (b == '0) r.status = wua_pkg::ST_DIVZERO; else r.value = a / b;
                wua_pkg::OP_MOD:
                    if (b == '0) r.status = wua_pkg::ST_DIVZERO; else r.value = a % b;
                wua_pkg::OP_LT:     r.flag = a < b;
                wua_pkg::OP_GT:     r.flag = a > b;
                wua_pkg::OP_LE:     r.flag = a <= b;
                wua_pkg::OP_GE:     r.flag = a >= b;
                wua_pkg::OP_EQ:     r.flag = a == b;
                wua_pkg::OP_NE:     r.flag = a != b;
                wua_pkg::OP_PASS:   r.value = a;
                wua_pkg::OP_NEGATE: if (a != '0) r.status = wua_pkg::ST_RANGE;
                wua_pkg::OP_AND:    r.value = a & b;
                wua_pkg::OP_OR:     r.value = a | b;
                wua_pkg::OP_XOR:    r.value = a ^ b;
                wua_pkg::OP_NOT:    r.value = ~a;
                wua_pkg::OP_SHL:    r.value = (cnt >= 9'd256) ? '0 : a << cnt;
                wua_pkg::OP_SHR:    r.value = (cnt >= 9'd256) ? '0 : a >> cnt;
                default:   ;
            endcase
            if (r.status != wua_pkg::ST_OK)
            begin
                r.value = '0;
                r.flag  = 1'b0;
            end
            return r;
        endfunction

        function void note_input(logic [4:0] op, wua_pkg::num_t a, wua_pkg::num_t b,
                                 logic [8:0] cnt);
            pending.push_back(compute(wua_pkg::op_t'(op), a, b, cnt));
        endfunction

        task report(string what, wua_pkg::num_t got, wua_pkg::num_t want);
            $display("MISMATCH %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(wua_pkg::num_t value, logic flag, logic [1:0] st);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word", value, '0);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) report("value", value, e.value);
            if (flag !== e.flag)
                report("compare_flag", wua_pkg::num_t'(flag), wua_pkg::num_t'(e.flag));
            if (st !== e.status)
                report("status", wua_pkg::num_t'(st), wua_pkg::num_t'(e.status));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  opcode = '0;
    logic [63:0] a_word0 = '0, a_word1 = '0, a_word2 = '0, a_word3 = '0;
    logic [63:0] b_word0 = '0, b_word1 = '0, b_word2 = '0, b_word3 = '0;
    logic [8:0]  shift_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] res_word0, res_word1, res_word2, res_word3;
    logic        compare_flag;
    logic [1:0]  status;

    alu_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_off = 1'b0;
    bit  drain_long_stall = 1'b0;

    wide_unsigned_alu_256 u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({res_word3, res_word2, res_word1, res_word0}, compare_flag, status);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            n = drain_long_stall ? 0 : gap_len();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic wua_pkg::num_t rand_num();
        wua_pkg::num_t v;
        int k;
        k = $urandom_range(0, 9);
        v = {rand_word(), rand_word(), rand_word(), rand_word()};
        // small operands make division and multiply results interesting
        if (k < 3) v = v >> (64 * $urandom_range(1, 3) + $urandom_range(0, 63));
        else if (k == 3) v = '0;
        return v;
    endfunction

    task automatic send_word(logic [4:0] op, wua_pkg::num_t a, wua_pkg::num_t b,
                             logic [8:0] cnt, bit idle);
        int n;
        n = idle ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        {a_word3, a_word2, a_word1, a_word0} <= a;
        {b_word3, b_word2, b_word1, b_word0} <= b;
        shift_count <= cnt;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, a, b, cnt);
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        wua_pkg::num_t ones, top;
        logic [4:0] op;
        ones = '1;
        top  = wua_pkg::num_t'(1) << 255;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(wua_pkg::OP_ADD, ones, wua_pkg::num_t'(1), 9'd0, 1'b0);
        send_word(wua_pkg::OP_ADD, ones, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_SUB, '0, wua_pkg::num_t'(1), 9'd0, 1'b0);
        send_word(wua_pkg::OP_SUB, ones, ones, 9'd0, 1'b0);
        send_word(wua_pkg::OP_MUL, ones, ones, 9'd0, 1'b0);
        send_word(wua_pkg::OP_MUL, top, wua_pkg::num_t'(2), 9'd0, 1'b0);
        send_word(wua_pkg::OP_MUL, top, wua_pkg::num_t'(1), 9'd0, 1'b0);
        send_word(wua_pkg::OP_DIV, ones, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_MOD, ones, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_DIV, ones, wua_pkg::num_t'(3), 9'd0, 1'b0);
        send_word(wua_pkg::OP_MOD, ones, top, 9'd0, 1'b0);
        for (int i = wua_pkg::OP_LT; i <= wua_pkg::OP_NE; i++)
        begin
            send_word(5'(i), ones, ones, 9'd0, 1'b0);
            send_word(5'(i), '0, ones, 9'd0, 1'b0);
        end
        send_word(wua_pkg::OP_PASS, ones, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_NEGATE, '0, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_NEGATE, top, '0, 9'd0, 1'b0);
        send_word(wua_pkg::OP_NOT, ones, ones, 9'd0, 1'b0);
        send_word(wua_pkg::OP_SHL, ones, '0, 9'd255, 1'b0);
        send_word(wua_pkg::OP_SHR, ones, '0, 9'd256, 1'b0);
        send_word(wua_pkg::OP_SHL, ones, '0, 9'd511, 1'b0);
        send_word(5'd31, ones, ones, 9'd511, 1'b0);
        wait_empty();

        for (int i = 0; i < 800; i++)
        begin
            if (i == 300)
            begin
                hold_off = 1'b1;
                drain_long_stall = 1'b0;
            end
            if (i == 700) wait_empty();
            if ($urandom_range(0, 19) == 0) op = 5'($urandom_range(19, 31));
            else op = 5'($urandom_range(0, 18));
            // no idle gaps during the hold-off, so the pipeline fills
            send_word(op, rand_num(), rand_num(), 9'($urandom),
                      !hold_off && ($urandom_range(0, 2) != 0));
        end
        wait_empty();
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
